### hdl/md5_decimal_nonce_pow_check_assert.svh
// Assertion macros shared by the hashing pipeline
`ifndef MD5_DECIMAL_NONCE_POW_CHECK_ASSERT_SVH
`define MD5_DECIMAL_NONCE_POW_CHECK_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MD5P_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MD5P_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/md5p_pkg.sv
`timescale 1ns / 1ps
package md5p_pkg;

    localparam int NONCE_W      = 31;
    localparam int DIFF_W       = 6;
    localparam int DIGITS       = 10;
    localparam int BCD_W        = 4 * DIGITS;
    localparam int BITS_PER_STG = 4;
    localparam int BCD_STAGES   = (NONCE_W + BITS_PER_STG - 1) / BITS_PER_STG;
    localparam int ROUNDS       = 64;
    localparam int NIBBLES      = 32;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [DIFF_W-1:0] DIFF_RESET = 6'd6;
    localparam logic [DIFF_W-1:0] DIFF_MAX   = 6'd32;

    // register index decoded from the bus address
    localparam logic REG_DIFFICULTY = 1'b0;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_md5_state;

    localparam logic [31:0] K_TAB [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int S_TAB [0:15] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // message word used by a round
    function automatic int md5_g(input int rnd);
        int g;
        if (rnd < 16)      g = rnd;
        else if (rnd < 32) g = (5 * rnd + 1) % 16;
        else if (rnd < 48) g = (3 * rnd + 5) % 16;
        else               g = (7 * rnd) % 16;
        return g;
    endfunction

    // rotate amount used by a round
    function automatic int md5_s(input int rnd);
        return S_TAB[((rnd / 16) * 4) + (rnd % 4)];
    endfunction

    // swap byte order of a word
    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

### hdl/md5p_bcd.sv
`timescale 1ns / 1ps
module md5p_bcd
    import md5p_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [NONCE_W-1:0]   i_nonce,
    output logic                 o_valid,
    output logic [NONCE_W-1:0]   o_nonce,
    output logic [BCD_W-1:0]     o_bcd
);

    // one shift-and-add-3 step
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] x,
                                               input logic bit_in);
        logic [BCD_W-1:0] y;
        y = x;
        for (int k = 0; k < DIGITS; k++) begin
            if (y[4*k +: 4] >= 4'd5) begin
                y[4*k +: 4] = y[4*k +: 4] + 4'd3;
            end
        end
        return {y[BCD_W-2:0], bit_in};
    endfunction

    logic                 r_vld   [0:BCD_STAGES];
    logic [NONCE_W-1:0]   r_nonce [0:BCD_STAGES];
    logic [BCD_W-1:0]     r_bcd   [0:BCD_STAGES];

    assign r_vld[0]   = i_valid;
    assign r_nonce[0] = i_nonce;
    assign r_bcd[0]   = '0;

    // convert up to four bits per stage, most significant first
    for (genvar s = 0; s < BCD_STAGES; s++) begin : g_stg
        logic [BCD_W-1:0] n_bcd;

        always_comb begin
            n_bcd = r_bcd[s];
            for (int k = 0; k < BITS_PER_STG; k++) begin
                if (NONCE_W - 1 - s * BITS_PER_STG - k >= 0) begin
                    n_bcd = dabble(n_bcd,
                        r_nonce[s][NONCE_W - 1 - s * BITS_PER_STG - k]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nonce[s+1] <= r_nonce[s];
                r_bcd[s+1]   <= n_bcd;
            end
        end
    end

    assign o_valid = r_vld[BCD_STAGES];
    assign o_nonce = r_nonce[BCD_STAGES];
    assign o_bcd   = r_bcd[BCD_STAGES];

endmodule

### hdl/md5p_rounds.sv
`timescale 1ns / 1ps
module md5p_rounds
    import md5p_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [NONCE_W-1:0]   i_nonce,
    input  logic [BCD_W-1:0]     i_bcd,
    output logic                 o_valid,
    output logic [NONCE_W-1:0]   o_nonce,
    output logic [127:0]         o_digest
);

    logic [7:0]          n_blk [0:63];
    logic [3:0]          w_len;
    logic [511:0]        n_words;

    logic                r_vld   [0:ROUNDS];
    logic [NONCE_W-1:0]  r_nonce [0:ROUNDS];
    logic [511:0]        r_words [0:ROUNDS];
    t_md5_state          r_st    [0:ROUNDS];

    logic                r_dvld;
    logic [NONCE_W-1:0]  r_dnonce;
    logic [127:0]        r_digest;

    // string length from the highest nonzero digit, at least one
    always_comb begin
        w_len = 4'd1;
        for (int j = 0; j < DIGITS; j++) begin
            if (i_bcd[4*j +: 4] != 4'd0) begin
                w_len = 4'(j + 1);
            end
        end
    end

    // build the padded block
    always_comb begin
        for (int j = 0; j < 64; j++) begin
            n_blk[j] = 8'h00;
        end
        for (int j = 0; j <= DIGITS; j++) begin
            if (4'(j) < w_len) begin
                n_blk[j] = ASCII_ZERO
                    + {4'd0, i_bcd[4*(int'(w_len) - 1 - j) +: 4]};
            end else if (4'(j) == w_len) begin
                n_blk[j] = PAD_BYTE;
            end
        end
        n_blk[56] = {1'b0, w_len, 3'b000};
        for (int i = 0; i < 16; i++) begin
            n_words[32*i +: 32] = {n_blk[4*i+3], n_blk[4*i+2],
                                   n_blk[4*i+1], n_blk[4*i]};
        end
    end

    // message stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nonce[0] <= i_nonce;
            r_words[0] <= n_words;
            r_st[0]    <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
        end
    end

    // one round per stage
    for (genvar r = 0; r < ROUNDS; r++) begin : g_rnd
        localparam int G = md5_g(r);
        localparam int S = md5_s(r);
        logic [31:0] w_f;
        logic [31:0] w_t;
        logic [31:0] w_rot;
        t_md5_state  n_st;

        always_comb begin
            if (r < 16) begin
                w_f = (r_st[r].b & r_st[r].c) | (~r_st[r].b & r_st[r].d);
            end else if (r < 32) begin
                w_f = (r_st[r].d & r_st[r].b) | (~r_st[r].d & r_st[r].c);
            end else if (r < 48) begin
                w_f = r_st[r].b ^ r_st[r].c ^ r_st[r].d;
            end else begin
                w_f = r_st[r].c ^ (r_st[r].b | ~r_st[r].d);
            end
            w_t   = r_st[r].a + w_f + K_TAB[r] + r_words[r][32*G +: 32];
            w_rot = (w_t << S) | (w_t >> (32 - S));
            n_st.a = r_st[r].d;
            n_st.b = r_st[r].b + w_rot;
            n_st.c = r_st[r].b;
            n_st.d = r_st[r].c;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[r+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[r+1] <= r_vld[r];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nonce[r+1] <= r_nonce[r];
                r_words[r+1] <= r_words[r];
                r_st[r+1]    <= n_st;
            end
        end
    end

    // add the initial value and put bytes in digest order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= 1'b0;
        end else if (i_en) begin
            r_dvld <= r_vld[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dnonce <= r_nonce[ROUNDS];
            r_digest <= {bswap32(r_st[ROUNDS].a + IV_A), bswap32(r_st[ROUNDS].b + IV_B),
                         bswap32(r_st[ROUNDS].c + IV_C), bswap32(r_st[ROUNDS].d + IV_D)};
        end
    end

    assign o_valid  = r_dvld;
    assign o_nonce  = r_dnonce;
    assign o_digest = r_digest;

endmodule

### hdl/md5_decimal_nonce_pow_check.sv
`timescale 1ns / 1ps
// Channel  | Valid           | Ready           | Payload
// ---------+-----------------+-----------------+-------------------------------------
// nonce    | i_nonce_valid   | o_nonce_ready   | i_nonce
// result   | o_result_valid  | i_result_ready  | o_match o_nonce_echo o_digest_high/low
// config   | i_psel&i_penable| o_pready (=1)   | i_paddr i_pwdata, read o_prdata
//
// One nonce is taken every cycle unless the output stalls; each result passes through
// 8 decimal conversion stages, 1 block stage, 64 round stages, 1 digest add and
// 1 compare/output register. The 64 MD5 rounds set the depth.
// The whole pipeline advances together whenever the output register is empty
// or being taken; a stall freezes every stage in place.
// Reset is synchronous and clears all valid bits; difficulty returns to 6.
`include "md5_decimal_nonce_pow_check_assert.svh"
module md5_decimal_nonce_pow_check
    import md5p_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_nonce_valid,
    output logic                 o_nonce_ready,
    input  logic [NONCE_W-1:0]   i_nonce,
    output logic                 o_result_valid,
    input  logic                 i_result_ready,
    output logic                 o_match,
    output logic [NONCE_W-1:0]   o_nonce_echo,
    output logic [63:0]          o_digest_high,
    output logic [63:0]          o_digest_low,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [2:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    output logic [31:0]          o_prdata,
    output logic                 o_pready
);

    logic               w_en;
    logic               w_bcd_vld;
    logic [NONCE_W-1:0] w_bcd_nonce;
    logic [BCD_W-1:0]   w_bcd;
    logic               w_dig_vld;
    logic [NONCE_W-1:0] w_dig_nonce;
    logic [127:0]       w_digest;
    logic               n_match;

    logic [DIFF_W-1:0]  r_difficulty;
    logic               r_out_vld;
    logic               r_match;
    logic [NONCE_W-1:0] r_nonce;
    logic [127:0]       r_digest;

    // advance everything when the output register is free
    assign w_en          = !r_out_vld || i_result_ready;
    assign o_nonce_ready = w_en;

    // configuration register
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_DIFFICULTY) ? {26'd0, r_difficulty} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_difficulty <= DIFF_RESET;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_DIFFICULTY)) begin
            r_difficulty <= i_pwdata[DIFF_W-1:0];
        end
    end

    md5p_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_nonce_valid),
        .i_nonce (i_nonce),
        .o_valid (w_bcd_vld),
        .o_nonce (w_bcd_nonce),
        .o_bcd   (w_bcd)
    );

    md5p_rounds u_rounds (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_bcd_vld),
        .i_nonce  (w_bcd_nonce),
        .i_bcd    (w_bcd),
        .o_valid  (w_dig_vld),
        .o_nonce  (w_dig_nonce),
        .o_digest (w_digest)
    );

    // check leading hex digits against difficulty
    always_comb begin
        n_match = (r_difficulty <= DIFF_MAX);
        for (int k = 0; k < NIBBLES; k++) begin
            if ((6'(k) < r_difficulty) && (w_digest[127 - 4*k -: 4] != 4'd0)) begin
                n_match = 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dig_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_match  <= n_match;
            r_nonce  <= w_dig_nonce;
            r_digest <= w_digest;
        end
    end

    assign o_result_valid = r_out_vld;
    assign o_match        = r_match;
    assign o_nonce_echo   = r_nonce;
    assign o_digest_high  = r_digest[127:64];
    assign o_digest_low   = r_digest[63:0];

    `MD5P_ASSERT_NOW(a_zero_diff_match, i_clk, i_rst_n,
        o_result_valid && $stable(r_difficulty) && r_difficulty == 6'd0, o_match,
        "zero difficulty must always match")
    `MD5P_ASSERT_NOW(a_big_diff_nomatch, i_clk, i_rst_n,
        o_result_valid && $stable(r_difficulty) && r_difficulty > DIFF_MAX, !o_match,
        "difficulty above 32 must never match")
    `MD5P_ASSERT_NOW(a_match_zero_bits, i_clk, i_rst_n,
        o_result_valid && o_match && $stable(r_difficulty) && r_difficulty >= 6'd8,
        o_digest_high[63:32] == 32'd0, "match with leading nonzero digest word")
    `MD5P_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        o_result_valid && !i_result_ready, o_result_valid && $stable(r_digest),
        "result changed while stalled")

endmodule
